// ----- design/obd2_poll_and_decode_unit_assert.svh -----
`ifndef OBD2_POLL_AND_DECODE_UNIT_ASSERT_SVH
`define OBD2_POLL_AND_DECODE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define OBD2_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("obd2 check failed");

// next-cycle implication, sampled on clock, off during reset
`define OBD2_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("obd2 check failed");

`endif

// ----- design/obd2_pkg.sv -----
`default_nettype none

package obd2_pkg;

   localparam int TABLE_MAX             = 7;
   localparam int TABLE_ENTRIES_DEFAULT = 7;
   localparam int SLOT_WIDTH            = 3;
   localparam int VALUE_WIDTH           = 33;

   localparam logic [15:0] INTERVAL_RESET = 16'd100;
   localparam logic [10:0] REQUEST_ID     = 11'h7DF;
   localparam logic [10:0] RESP_ID_LOW    = 11'h7E8;
   localparam logic [10:0] RESP_ID_HIGH   = 11'h7EF;
   localparam logic [7:0]  MODE_OK        = 8'h41;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   localparam logic CSR_POLL_ENABLE = 1'b0;
   localparam logic CSR_INTERVAL    = 1'b1;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_REQUEST  = 2'd1,
      KIND_DECODED  = 2'd2,
      KIND_IGNORED  = 2'd3
   } result_kind_type;

   typedef enum logic [2:0] {
      FORM_A,
      FORM_A_MINUS_40,
      FORM_PERCENT,
      FORM_DIV4,
      FORM_DIV20,
      FORM_DIV1000
   } form_type;

   localparam logic [7:0] SLOT_PID [TABLE_MAX] = '{
      8'h04, 8'h05, 8'h0C, 8'h0D, 8'h2F, 8'h42, 8'h5E
   };

   localparam form_type SLOT_FORM [TABLE_MAX] = '{
      FORM_PERCENT, FORM_A_MINUS_40, FORM_DIV4, FORM_A,
      FORM_PERCENT, FORM_DIV1000, FORM_DIV20
   };

   typedef struct packed {
      logic                          hit;
      logic [SLOT_WIDTH-1:0]         slot;
      logic signed [VALUE_WIDTH-1:0] value;
   } frame_result_type;

endpackage

`default_nettype wire

// ----- design/obd2_decoder.sv -----
`default_nettype none

module obd2_decoder #(
   parameter int TABLE_ENTRIES = obd2_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic [10:0]              can_id,
   input  wire logic [3:0]               length_code,
   input  wire logic [7:0]               mode_reply,
   input  wire logic [7:0]               pid_code,
   input  wire logic [7:0]               byte_a,
   input  wire logic [7:0]               byte_b,
   output obd2_pkg::frame_result_type    result
);

   logic                          frame_ok;
   logic                          match;
   logic [obd2_pkg::SLOT_WIDTH-1:0] slot;
   logic [7:0]                    a;
   logic [7:0]                    b;
   logic [15:0]                   ab;
   logic signed [8:0]             a_minus_40;
   logic [22:0]                   pct_prod;
   logic [22:0]                   pct_frac;
   logic [22:0]                   pct;
   logic [27:0]                   div20_whole;
   logic [36:0]                   div20_prod;
   logic [27:0]                   div20;
   logic [22:0]                   div1000_whole;
   logic [45:0]                   div1000_prod;
   logic [22:0]                   div1000;
   logic signed [obd2_pkg::VALUE_WIDTH-1:0] value;

   assign frame_ok = (can_id >= obd2_pkg::RESP_ID_LOW) && (can_id <= obd2_pkg::RESP_ID_HIGH)
                     && (length_code >= 4'd3) && (mode_reply == obd2_pkg::MODE_OK);

   always_comb begin
      match = 1'b0;
      slot  = '0;
      for (int i = 0; i < obd2_pkg::TABLE_MAX; i++) begin
         if (i < TABLE_ENTRIES && !match && pid_code == obd2_pkg::SLOT_PID[i]) begin
            match = 1'b1;
            slot  = obd2_pkg::SLOT_WIDTH'(i);
         end
      end
   end

   assign a  = (length_code > 4'd3) ? byte_a : 8'd0;
   assign b  = (length_code > 4'd4) ? byte_b : 8'd0;
   assign ab = {a, b};

   assign a_minus_40 = $signed({1'b0, a}) - 9'sd40;

   // floor(a*6553600/255) = a*25700 + floor(a*100/255)
   assign pct_prod = 23'(a) * 23'd25700;
   assign pct_frac = (pct_prod + 23'd257) >> 16;
   assign pct      = pct_prod + pct_frac;

   // floor(ab*16384/5) = ab*3276 + floor(4ab/5)
   assign div20_whole = 28'(ab) * 28'd3276;
   assign div20_prod  = 37'(ab) * 37'd1677724;
   assign div20       = div20_whole + 28'(div20_prod[36:21]);

   // floor(ab*8192/125) = ab*65 + floor(67ab/125)
   assign div1000_whole = 23'(ab) * 23'd65;
   assign div1000_prod  = 46'(ab) * 46'd575525645;
   assign div1000       = div1000_whole + 23'(div1000_prod[45:30]);

   always_comb begin
      unique case (obd2_pkg::SLOT_FORM[slot])
         obd2_pkg::FORM_A:          value = {9'b0, a, 16'b0};
         obd2_pkg::FORM_A_MINUS_40: value = {{8{a_minus_40[8]}}, a_minus_40, 16'b0};
         obd2_pkg::FORM_PERCENT:    value = {10'b0, pct};
         obd2_pkg::FORM_DIV4:       value = {3'b0, ab, 14'b0};
         obd2_pkg::FORM_DIV20:      value = {5'b0, div20};
         obd2_pkg::FORM_DIV1000:    value = {10'b0, div1000};
         default:                   value = {9'b0, ab, 8'b0};
      endcase
   end

   assign result.hit   = frame_ok && match;
   assign result.slot  = slot;
   assign result.value = value;

endmodule

`default_nettype wire

// ----- design/obd2_poll_and_decode_unit.sv -----
// OBD-II Mode 01 poller and decoder.
// Request channel (req_valid/req_ready): one request per tick or received
// CAN frame; req_type selects which, req_now_ms carries the time.
// Response channel (rsp_valid/rsp_ready): exactly one response per request.
// A tick gives kind 1 with the PID to send on 0x7DF when polling is enabled
// and the interval has elapsed, else kind 0. A frame gives kind 2 with a Q16
// value, slot and stamp, or kind 3 when it is not a known response.
// Config port (csr_write_enable/csr_index/csr_write_data): index 0 poll
// enable, index 1 request interval in ms; the user must ensure they are
// written only while idle, which the block does not enforce. Throughput
// is one request per cycle: decode and poll logic sit between the request
// ports and a single response register; the state updates at acceptance.
// req_ready drops only while a response is held and rsp_ready is low; the
// held response stays stable until taken.
// Synchronous reset: polling off, interval 100 ms, slot 0, count 0, time 0,
// response register empty.
`default_nettype none

module obd2_poll_and_decode_unit #(
   parameter int TABLE_ENTRIES = obd2_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [10:0] req_can_id,
   input  wire logic [3:0]  req_length_code,
   input  wire logic [7:0]  req_mode_reply,
   input  wire logic [7:0]  req_pid_code,
   input  wire logic [7:0]  req_byte_a,
   input  wire logic [7:0]  req_byte_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_request_pid,
   output logic [2:0]       rsp_slot_index,
   output logic signed [32:0] rsp_value_q16,
   output logic [31:0]      rsp_stamp_ms,
   output logic [31:0]      rsp_responses_seen
);

   localparam int SW = obd2_pkg::SLOT_WIDTH;

   logic              poll_enable_ff;
   logic [15:0]       interval_ff;
   logic [31:0]       last_request_time_ff, last_request_time_in;
   logic [SW-1:0]     next_slot_ff, next_slot_in;
   logic [31:0]       response_counter_ff, response_counter_in;

   logic              rsp_valid_ff;
   obd2_pkg::result_kind_type kind_ff, kind_in;
   logic [7:0]        request_pid_ff, request_pid_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic signed [32:0] value_ff, value_in;
   logic [31:0]       stamp_ff, stamp_in;

   logic              accept;
   logic [SW-1:0]     cur_slot;
   logic [31:0]       elapsed;
   obd2_pkg::frame_result_type frame;

   obd2_decoder #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_decoder (
      .can_id      (req_can_id),
      .length_code (req_length_code),
      .mode_reply  (req_mode_reply),
      .pid_code    (req_pid_code),
      .byte_a      (req_byte_a),
      .byte_b      (req_byte_b),
      .result      (frame)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign cur_slot = (32'(next_slot_ff) >= 32'(TABLE_ENTRIES)) ? '0 : next_slot_ff;
   assign elapsed  = req_now_ms - last_request_time_ff;

   always_comb begin
      last_request_time_in = last_request_time_ff;
      next_slot_in         = next_slot_ff;
      response_counter_in  = response_counter_ff;
      kind_in              = obd2_pkg::KIND_NONE;
      request_pid_in       = 8'd0;
      slot_in              = '0;
      value_in             = '0;
      stamp_in             = 32'd0;
      if (req_type == obd2_pkg::REQ_TICK) begin
         if (poll_enable_ff && elapsed >= 32'(interval_ff)) begin
            last_request_time_in = req_now_ms;
            kind_in              = obd2_pkg::KIND_REQUEST;
            request_pid_in       = obd2_pkg::SLOT_PID[cur_slot];
            slot_in              = cur_slot;
            next_slot_in         = (32'(cur_slot) == 32'(TABLE_ENTRIES - 1)) ? '0
                                   : cur_slot + SW'(1);
         end
      end else if (frame.hit) begin
         kind_in             = obd2_pkg::KIND_DECODED;
         slot_in             = frame.slot;
         value_in            = frame.value;
         stamp_in            = req_now_ms;
         response_counter_in = response_counter_ff + 32'd1;
      end else begin
         kind_in = obd2_pkg::KIND_IGNORED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_enable_ff <= 1'b0;
         interval_ff    <= obd2_pkg::INTERVAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            obd2_pkg::CSR_POLL_ENABLE: poll_enable_ff <= csr_write_data[0];
            obd2_pkg::CSR_INTERVAL:    interval_ff    <= csr_write_data;
            default:                   poll_enable_ff <= poll_enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_request_time_ff <= 32'd0;
         next_slot_ff         <= '0;
         response_counter_ff  <= 32'd0;
         rsp_valid_ff         <= 1'b0;
      end else if (accept) begin
         last_request_time_ff <= last_request_time_in;
         next_slot_ff         <= next_slot_in;
         response_counter_ff  <= response_counter_in;
         rsp_valid_ff         <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff        <= kind_in;
         request_pid_ff <= request_pid_in;
         slot_ff        <= slot_in;
         value_ff       <= value_in;
         stamp_ff       <= stamp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_request_pid    = request_pid_ff;
   assign rsp_slot_index     = slot_ff;
   assign rsp_value_q16      = value_ff;
   assign rsp_stamp_ms       = stamp_ff;
   assign rsp_responses_seen = response_counter_ff;

endmodule

`default_nettype wire

// ----- design/obd2_checker.sv -----
`default_nettype none
`include "obd2_poll_and_decode_unit_assert.svh"

module obd2_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_type,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_result_kind,
   input wire logic [7:0]  rsp_request_pid,
   input wire logic [2:0]  rsp_slot_index,
   input wire logic signed [32:0] rsp_value_q16,
   input wire logic [31:0] rsp_stamp_ms,
   input wire logic [31:0] rsp_responses_seen
);

   logic         tick_taken;
   logic         frame_taken;
   logic         rsp_held;
   logic         tick_kind_ok;
   logic         frame_kind_ok;
   logic         not_decoded;
   logic         idle_fields_zero;
   logic [109:0] rsp_payload;

   assign tick_taken  = req_valid && req_ready && req_type == obd2_pkg::REQ_TICK;
   assign frame_taken = req_valid && req_ready && req_type == obd2_pkg::REQ_FRAME;
   assign rsp_held    = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_result_kind, rsp_request_pid, rsp_slot_index, rsp_value_q16,
                         rsp_stamp_ms, rsp_responses_seen};

   assign tick_kind_ok  = rsp_result_kind == obd2_pkg::KIND_NONE
                          || rsp_result_kind == obd2_pkg::KIND_REQUEST;
   assign frame_kind_ok = rsp_result_kind == obd2_pkg::KIND_DECODED
                          || rsp_result_kind == obd2_pkg::KIND_IGNORED;
   assign not_decoded      = rsp_valid && rsp_result_kind != obd2_pkg::KIND_DECODED;
   assign idle_fields_zero = rsp_value_q16 == 33'sd0 && rsp_stamp_ms == 32'd0;

   `OBD2_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_payload))

   `OBD2_ASSERT_NEXT(a_tick_kind, tick_taken, rsp_valid && tick_kind_ok)

   `OBD2_ASSERT_NEXT(a_frame_kind, frame_taken, rsp_valid && frame_kind_ok)

   `OBD2_ASSERT_SAME(a_idle_fields, not_decoded, idle_fields_zero)

endmodule

bind obd2_poll_and_decode_unit obd2_checker u_checker (.*);

`default_nettype wire

// ----- tb/obd2_response_check.sv -----
`timescale 1ns / 1ps

module obd2_response_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_type,
   input  logic [31:0]        req_now_ms,
   input  logic [10:0]        req_can_id,
   input  logic [3:0]         req_length_code,
   input  logic [7:0]         req_mode_reply,
   input  logic [7:0]         req_pid_code,
   input  logic [7:0]         req_byte_a,
   input  logic [7:0]         req_byte_b,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_result_kind,
   input  logic [7:0]         rsp_request_pid,
   input  logic [2:0]         rsp_slot_index,
   input  logic signed [32:0] rsp_value_q16,
   input  logic [31:0]        rsp_stamp_ms,
   input  logic [31:0]        rsp_responses_seen,
   output int unsigned        mismatch_count,
   output int unsigned        awaited_count
);
   import obd2_pkg::*;

   typedef struct packed {
      result_kind_type    kind;
      logic [7:0]         pid;
      logic [2:0]         slot;
      logic signed [32:0] value;
      logic [31:0]        stamp;
      logic [31:0]        seen;
   } pid_response_t;

   pid_response_t awaited_responses[$];

   logic        poll_on;
   logic [15:0] interval_ms;
   logic [31:0] last_poll_ms;
   logic [2:0]  poll_slot;
   logic [31:0] decoded_total;
   int unsigned misses = 0;

   initial awaited_count = 0;
   assign mismatch_count = misses;

   function automatic logic [7:0] pid_in_slot(input logic [2:0] slot);
      case (slot)
         3'd0:    return 8'h04;
         3'd1:    return 8'h05;
         3'd2:    return 8'h0C;
         3'd3:    return 8'h0D;
         3'd4:    return 8'h2F;
         3'd5:    return 8'h42;
         default: return 8'h5E;
      endcase
   endfunction

   // floor of the exact scaled value, kept as a 33-bit two's complement pattern
   function automatic logic signed [32:0] scaled_value(input logic [2:0] slot,
                                                      input logic [7:0] a,
                                                      input logic [7:0] b);
      logic [63:0] ab;
      logic [63:0] q;
      ab = {48'd0, a, b};
      case (slot)
         3'd0, 3'd4: q = ({56'd0, a} * 64'd6553600) / 64'd255;
         3'd1:       q = ({56'd0, a} << 16) - (64'd40 << 16);
         3'd2:       q = ab << 14;
         3'd3:       q = {56'd0, a} << 16;
         3'd5:       q = (ab << 16) / 64'd1000;
         default:    q = (ab << 16) / 64'd20;
      endcase
      return q[32:0];
   endfunction

   always @(posedge clock) begin
      pid_response_t want;
      pid_response_t got;
      logic [31:0]   elapsed;
      logic [7:0]    a_val;
      logic [7:0]    b_val;
      logic [2:0]    hit_slot;
      logic          hit;
      if (reset) begin
         poll_on       = 1'b0;
         interval_ms   = INTERVAL_RESET;
         last_poll_ms  = '0;
         poll_slot     = '0;
         decoded_total = '0;
         awaited_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind  = result_kind_type'(rsp_result_kind);
            got.pid   = rsp_request_pid;
            got.slot  = rsp_slot_index;
            got.value = rsp_value_q16;
            got.stamp = rsp_stamp_ms;
            got.seen  = rsp_responses_seen;
            if (awaited_responses.size() == 0) begin
               misses++;
               if (misses <= 10)
                  $display("unexpected response: kind %0d pid %h slot %0d value %0d",
                           got.kind, got.pid, got.slot, got.value);
            end else begin
               want = awaited_responses.pop_front();
               if (got.kind !== want.kind || got.pid !== want.pid ||
                   got.slot !== want.slot || got.value !== want.value ||
                   got.stamp !== want.stamp || got.seen !== want.seen) begin
                  misses++;
                  if (misses <= 10) begin
                     $display("expected: kind %0d pid %h slot %0d value %0d stamp %0d seen %0d",
                              want.kind, want.pid, want.slot, want.value, want.stamp,
                              want.seen);
                     $display("actual:   kind %0d pid %h slot %0d value %0d stamp %0d seen %0d",
                              got.kind, got.pid, got.slot, got.value, got.stamp, got.seen);
                  end
               end
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_POLL_ENABLE)
               poll_on = csr_write_data[0];
            else
               interval_ms = csr_write_data;
         end
         if (req_valid && req_ready) begin
            want = '0;
            if (req_type == REQ_TICK) begin
               want.kind = KIND_NONE;
               elapsed = req_now_ms - last_poll_ms;
               if (poll_on && elapsed >= {16'd0, interval_ms}) begin
                  last_poll_ms = req_now_ms;
                  want.kind = KIND_REQUEST;
                  want.pid  = pid_in_slot(poll_slot);
                  want.slot = poll_slot;
                  poll_slot = (poll_slot == 3'(TABLE_MAX - 1)) ? 3'd0 : poll_slot + 3'd1;
               end
            end else begin
               want.kind = KIND_IGNORED;
               if (req_can_id >= RESP_ID_LOW && req_can_id <= RESP_ID_HIGH &&
                   req_length_code >= 4'd3 && req_mode_reply == MODE_OK) begin
                  hit = 1'b0;
                  hit_slot = '0;
                  for (int s = 0; s < TABLE_MAX; s++) begin
                     if (!hit && pid_in_slot(3'(s)) == req_pid_code) begin
                        hit = 1'b1;
                        hit_slot = 3'(s);
                     end
                  end
                  if (hit) begin
                     a_val = (req_length_code > 4'd3) ? req_byte_a : 8'd0;
                     b_val = (req_length_code > 4'd4) ? req_byte_b : 8'd0;
                     want.kind  = KIND_DECODED;
                     want.slot  = hit_slot;
                     want.value = scaled_value(hit_slot, a_val, b_val);
                     want.stamp = req_now_ms;
                     decoded_total = decoded_total + 32'd1;
                  end
               end
            end
            want.seen = decoded_total;
            awaited_responses.push_back(want);
         end
      end
      awaited_count <= awaited_responses.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import obd2_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = 1'b0;
   logic [15:0]        csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = 1'b0;
   logic [31:0]        req_now_ms = '0;
   logic [10:0]        req_can_id = '0;
   logic [3:0]         req_length_code = '0;
   logic [7:0]         req_mode_reply = '0;
   logic [7:0]         req_pid_code = '0;
   logic [7:0]         req_byte_a = '0;
   logic [7:0]         req_byte_b = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic [7:0]         rsp_request_pid;
   logic [2:0]         rsp_slot_index;
   logic signed [32:0] rsp_value_q16;
   logic [31:0]        rsp_stamp_ms;
   logic [31:0]        rsp_responses_seen;

   int unsigned mismatch_count;
   int unsigned awaited_count;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   logic        long_stall_go = 1'b0;
   logic [15:0] cur_interval = INTERVAL_RESET;
   logic [31:0] vehicle_ms = '0;

   obd2_poll_and_decode_unit dut (.*);

   obd2_response_check response_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hold off the response side for a long stretch on request
   always @(posedge clock) begin
      if (long_stall_go) begin
         long_stall_go = 1'b0;
         stall_left = 300;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 200000) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic offer(input logic kind, input logic [31:0] now, input logic [10:0] id,
                        input logic [3:0] len, input logic [7:0] mode, input logic [7:0] pid,
                        input logic [7:0] a, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_now_ms      <= now;
      req_can_id      <= id;
      req_length_code <= len;
      req_mode_reply  <= mode;
      req_pid_code    <= pid;
      req_byte_a      <= a;
      req_byte_b      <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic offer_random();
      logic [31:0] span;
      logic [10:0] id;
      logic [3:0]  len;
      logic [7:0]  mode;
      logic [7:0]  pid;
      logic [7:0]  a;
      logic [7:0]  b;
      if ($urandom_range(1) == 0) begin
         span = (cur_interval == 0) ? 32'd50 : {16'd0, cur_interval};
         case ($urandom_range(9))
            0:       vehicle_ms = $urandom;
            1:       vehicle_ms += {16'd0, cur_interval};
            2:       vehicle_ms += 32'd0;
            default: vehicle_ms += $urandom_range(0, 2 * span);
         endcase
         offer(REQ_TICK, vehicle_ms, 11'($urandom), 4'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         if ($urandom_range(19) == 0)
            vehicle_ms = $urandom;
         else
            vehicle_ms += $urandom_range(0, 3);
         id   = RESP_ID_LOW + 11'($urandom_range(7));
         len  = ($urandom_range(3) == 0) ? 4'($urandom_range(3, 15)) : 4'd8;
         mode = MODE_OK;
         case ($urandom_range(6))
            0:       pid = 8'h04;
            1:       pid = 8'h05;
            2:       pid = 8'h0C;
            3:       pid = 8'h0D;
            4:       pid = 8'h2F;
            5:       pid = 8'h42;
            default: pid = 8'h5E;
         endcase
         // break some frames in randomly chosen fields
         if ($urandom_range(4) == 0) begin
            if ($urandom_range(1) == 0) begin
               case ($urandom_range(2))
                  0:       id = RESP_ID_LOW - 11'd1;
                  1:       id = RESP_ID_HIGH + 11'd1;
                  default: id = 11'($urandom);
               endcase
            end
            if ($urandom_range(1) == 0) len = 4'($urandom);
            if ($urandom_range(1) == 0) mode = 8'($urandom);
            if ($urandom_range(1) == 0) pid = 8'($urandom);
         end
         case ($urandom_range(7))
            0:       a = 8'h00;
            1:       a = 8'hFF;
            default: a = 8'($urandom);
         endcase
         case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
         endcase
         offer(REQ_FRAME, vehicle_ms, id, len, mode, pid, a, b);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_polling(input logic on, input logic [15:0] interval);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_POLL_ENABLE;
      csr_write_data   <= {15'd0, on};
      @(posedge clock);
      csr_index        <= CSR_INTERVAL;
      csr_write_data   <= interval;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      cur_interval = interval;
   endtask

   initial begin
      logic        on;
      logic [15:0] interval;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // polling off after reset: ticks do nothing, frames still decode
      offer(REQ_TICK, 32'd500, 11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      offer(REQ_FRAME, 32'd501, RESP_ID_LOW, 4'd8, MODE_OK, 8'h04, 8'hFF, 8'h00);
      drain();

      // zero interval: every tick polls, walk the whole table and wrap
      set_polling(1'b1, 16'd0);
      offer(REQ_TICK, 32'd0, 11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      offer(REQ_TICK, 32'd0, 11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      offer(REQ_TICK, 32'hFFFF_FFFF, 11'h7FF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      offer(REQ_TICK, 32'd1, 11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      offer(REQ_TICK, 32'd2, 11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      offer(REQ_TICK, 32'd3, 11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      offer(REQ_TICK, 32'd4, 11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      offer(REQ_TICK, 32'd5, 11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);

      // each formula at its extremes, short frames and rejects
      offer(REQ_FRAME, 32'd10, RESP_ID_LOW, 4'd8, MODE_OK, 8'h05, 8'h00, 8'h00);
      offer(REQ_FRAME, 32'd11, RESP_ID_LOW, 4'd8, MODE_OK, 8'h0C, 8'hFF, 8'hFF);
      offer(REQ_FRAME, 32'd12, RESP_ID_LOW, 4'd5, MODE_OK, 8'h0D, 8'hFF, 8'h00);
      offer(REQ_FRAME, 32'd13, RESP_ID_LOW, 4'd6, MODE_OK, 8'h2F, 8'hFF, 8'h12);
      offer(REQ_FRAME, 32'd14, RESP_ID_LOW, 4'd15, MODE_OK, 8'h42, 8'hFF, 8'hFF);
      offer(REQ_FRAME, 32'hFFFF_FFFF, RESP_ID_HIGH, 4'd8, MODE_OK, 8'h5E, 8'hFF, 8'hFF);
      offer(REQ_FRAME, 32'd16, RESP_ID_LOW, 4'd3, MODE_OK, 8'h0C, 8'hAB, 8'hCD);
      offer(REQ_FRAME, 32'd17, RESP_ID_LOW, 4'd4, MODE_OK, 8'h42, 8'hAB, 8'hCD);
      offer(REQ_FRAME, 32'd18, RESP_ID_LOW, 4'd2, MODE_OK, 8'h0D, 8'h11, 8'h22);
      offer(REQ_FRAME, 32'd19, RESP_ID_LOW - 11'd1, 4'd8, MODE_OK, 8'h0D, 8'h11, 8'h22);
      offer(REQ_FRAME, 32'd20, RESP_ID_HIGH + 11'd1, 4'd8, MODE_OK, 8'h0D, 8'h11, 8'h22);
      offer(REQ_FRAME, 32'd21, RESP_ID_LOW, 4'd8, 8'h40, 8'h0D, 8'h11, 8'h22);
      offer(REQ_FRAME, 32'd22, RESP_ID_LOW, 4'd8, MODE_OK, 8'h00, 8'h11, 8'h22);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0:       begin on = 1'b1; interval = 16'd1;     end
            1:       begin on = 1'b1; interval = 16'd65535; end
            2:       begin on = 1'b0; interval = 16'd100;   end
            3:       begin on = 1'b1; interval = 16'd0;     end
            4:       begin on = 1'b1; interval = 16'd37;    end
            5:       begin on = 1'b1; interval = 16'd1000;  end
            6:       begin on = 1'b0; interval = 16'd65535; end
            default: begin on = 1'b1; interval = 16'd5;     end
         endcase
         set_polling(on, interval);
         case (ph % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 57; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 9;  stall_pct = 9;  end
         endcase
         if (ph == 4) begin
            long_stall_go = 1'b1;
            for (int n = 0; n < 30; n++) offer_random();
         end
         for (int n = 0; n < 228; n++) offer_random();
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
